// File: sv/tmc_pkg.sv
// types and constants shared by the trs matrix compose block
package tmc_pkg;

  localparam int TermW = 35;
  localparam int ProdW = 52;
  localparam int DropW = 20;

  typedef logic signed [31:0] q16_t;
  typedef logic signed [15:0] q8_t;
  typedef logic signed [15:0] q14_t;
  typedef logic signed [TermW-1:0] term_t;
  typedef logic signed [ProdW-1:0] prod_t;

  localparam term_t OneQ28 = 35'sd268435456;
  localparam prod_t RoundHalf = 52'sd524288;
  localparam q16_t OneQ16 = 32'sd65536;
  localparam q16_t SatMax = 32'sh7fffffff;
  localparam q16_t SatMin = 32'sh80000000;
  localparam logic [1:0] LastCol = 2'd3;

  typedef struct packed {
    q16_t pos_x;
    q16_t pos_y;
    q16_t pos_z;
    q14_t quat_x;
    q14_t quat_y;
    q14_t quat_z;
    q14_t quat_w;
    q8_t  scale_x;
    q8_t  scale_y;
    q8_t  scale_z;
  } in_word_t;

  typedef struct packed {
    logic [1:0] column;
    q16_t       elem_row0;
    q16_t       elem_row1;
    q16_t       elem_row2;
    q16_t       elem_row3;
    logic       last;
  } out_word_t;

  // r[col][row] in units of 2^-28
  typedef struct packed {
    term_t [2:0][2:0] r;
    q8_t [2:0]        scale;
    q16_t [2:0]       pos;
  } terms_t;

endpackage

// File: sv/trs_matrix_compose.sv
// top level: quaternion, scale and translation to a column-major 4x4 matrix
//
// usage:
//   input channel in_valid_i / in_ready_o / in_word_i carries one word with
//   translation (Q16.16), quaternion (Q2.14) and per-axis scale (Q8.8).
//   output channel out_valid_o / out_ready_i / out_word_o carries four words
//   per input word, columns 0, 1, 2, 3 in order, last set on column 3.
// path: column 0 reaches the output through the product, term, column
//   multiply and round/saturate registers.
// throughput: one output word per cycle while out_ready_i is high; the
//   column sequencer that walks the held terms sets this.
//   A second input word is taken while the previous one is still being
//   sent, so the output runs without gaps under continuous load.
// reset: asynchronous, active low; all pipeline valid bits and the column
//   counter clear, no output word is pending afterwards.
// stall: when out_ready_i is low a full output stage holds its word and an
//   earlier stage holds once the stages after it are full; back pressure
//   reaches in_ready_o once all are full. Nothing is dropped or sent twice.
module trs_matrix_compose import tmc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  function automatic q16_t round_sat(input prod_t p);
    prod_t s;
    q16_t  r;
    s = p + RoundHalf;
    if (s[ProdW-1:DropW+31] == '0 || s[ProdW-1:DropW+31] == '1) begin
      r = s[DropW+31:DropW];
    end else if (s[ProdW-1]) begin
      r = SatMin;
    end else begin
      r = SatMax;
    end
    return r;
  endfunction

  logic          terms_valid, terms_ready;
  terms_t        terms;
  logic [1:0]    col_q;
  logic          issue;
  logic          b1_v_q, b1_ready;
  logic [1:0]    b1_col_q;
  prod_t [2:0]   b1_prod_q, b1_prod_d;
  logic          out_v_q, out_ready;
  out_word_t     out_word_q, out_word_d;

  tmc_quat_terms u_terms (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_word_i     (in_word_i),
    .terms_valid_o (terms_valid),
    .terms_ready_i (terms_ready),
    .terms_o       (terms)
  );

  assign out_ready   = !out_v_q || out_ready_i;
  assign b1_ready    = !b1_v_q || out_ready;
  assign issue       = terms_valid && b1_ready;
  assign terms_ready = b1_ready && (col_q == LastCol);

  // column multiply; translation column rides the same rounding path
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (col_q == LastCol) begin
        b1_prod_d[k] = ProdW'($signed(terms.pos[k])) <<< DropW;
      end else begin
        b1_prod_d[k] = ProdW'($signed(terms.r[col_q][k])) *
                       ProdW'($signed(terms.scale[col_q]));
      end
    end
  end

  always_comb begin
    out_word_d.column    = b1_col_q;
    out_word_d.elem_row0 = round_sat(b1_prod_q[0]);
    out_word_d.elem_row1 = round_sat(b1_prod_q[1]);
    out_word_d.elem_row2 = round_sat(b1_prod_q[2]);
    out_word_d.elem_row3 = (b1_col_q == LastCol) ? OneQ16 : '0;
    out_word_d.last      = (b1_col_q == LastCol);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      b1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (issue) begin
        col_q <= col_q + 2'd1;
      end
      if (b1_ready) begin
        b1_v_q <= terms_valid;
      end
      if (out_ready) begin
        out_v_q <= b1_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      b1_col_q  <= col_q;
      b1_prod_q <= b1_prod_d;
    end
    if (out_ready && b1_v_q) begin
      out_word_q <= out_word_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_word_o  = out_word_q;

endmodule

// File: sv/tmc_quat_terms.sv
// two-stage pipeline from quaternion to unscaled rotation terms
module tmc_quat_terms import tmc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_word_t in_word_i,
  output logic     terms_valid_o,
  input  logic     terms_ready_i,
  output terms_t   terms_o
);

  typedef struct packed {
    q16_t xx;
    q16_t yy;
    q16_t zz;
    q16_t xy;
    q16_t xz;
    q16_t yz;
    q16_t wx;
    q16_t wy;
    q16_t wz;
  } prods_t;

  function automatic term_t dbl_add(input q16_t a, input q16_t b);
    term_t s;
    s = TermW'(a) + TermW'(b);
    return s <<< 1;
  endfunction

  function automatic term_t dbl_sub(input q16_t a, input q16_t b);
    term_t s;
    s = TermW'(a) - TermW'(b);
    return s <<< 1;
  endfunction

  logic       s1_v_q, s2_v_q;
  logic       s1_ready, s2_ready;
  prods_t     s1_prod_q, s1_prod_d;
  q8_t [2:0]  s1_scale_q;
  q16_t [2:0] s1_pos_q;
  terms_t     s2_terms_q, s2_terms_d;
  q16_t       qx, qy, qz, qw;

  assign s2_ready   = !s2_v_q || terms_ready_i;
  assign s1_ready   = !s1_v_q || s2_ready;
  assign in_ready_o = s1_ready;

  assign qx = q16_t'(in_word_i.quat_x);
  assign qy = q16_t'(in_word_i.quat_y);
  assign qz = q16_t'(in_word_i.quat_z);
  assign qw = q16_t'(in_word_i.quat_w);

  always_comb begin
    s1_prod_d.xx = qx * qx;
    s1_prod_d.yy = qy * qy;
    s1_prod_d.zz = qz * qz;
    s1_prod_d.xy = qx * qy;
    s1_prod_d.xz = qx * qz;
    s1_prod_d.yz = qy * qz;
    s1_prod_d.wx = qw * qx;
    s1_prod_d.wy = qw * qy;
    s1_prod_d.wz = qw * qz;
  end

  always_comb begin
    s2_terms_d.r[0][0] = OneQ28 - dbl_add(s1_prod_q.yy, s1_prod_q.zz);
    s2_terms_d.r[0][1] = dbl_add(s1_prod_q.xy, s1_prod_q.wz);
    s2_terms_d.r[0][2] = dbl_sub(s1_prod_q.xz, s1_prod_q.wy);
    s2_terms_d.r[1][0] = dbl_sub(s1_prod_q.xy, s1_prod_q.wz);
    s2_terms_d.r[1][1] = OneQ28 - dbl_add(s1_prod_q.xx, s1_prod_q.zz);
    s2_terms_d.r[1][2] = dbl_add(s1_prod_q.yz, s1_prod_q.wx);
    s2_terms_d.r[2][0] = dbl_add(s1_prod_q.xz, s1_prod_q.wy);
    s2_terms_d.r[2][1] = dbl_sub(s1_prod_q.yz, s1_prod_q.wx);
    s2_terms_d.r[2][2] = OneQ28 - dbl_add(s1_prod_q.xx, s1_prod_q.yy);
    s2_terms_d.scale   = s1_scale_q;
    s2_terms_d.pos     = s1_pos_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_v_q <= in_valid_i;
      end
      if (s2_ready) begin
        s2_v_q <= s1_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      s1_prod_q  <= s1_prod_d;
      s1_scale_q <= {in_word_i.scale_z, in_word_i.scale_y, in_word_i.scale_x};
      s1_pos_q   <= {in_word_i.pos_z, in_word_i.pos_y, in_word_i.pos_x};
    end
    if (s2_ready && s1_v_q) begin
      s2_terms_q <= s2_terms_d;
    end
  end

  assign terms_valid_o = s2_v_q;
  assign terms_o       = s2_terms_q;

endmodule

// File: tb/trs_matrix_compose_checker.sv
// channel monitor for trs_matrix_compose: predicts the four columns of each word and compares
`timescale 1ns / 100ps
module trs_matrix_compose_checker import tmc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_word_t  in_word_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_word_t out_word_i,
  output int        errors_o,
  output int        pending_o
);

  out_word_t column_q[$];

  // rotation term (2^-28) times Q8.8 scale, rounded half up to Q16.16 and clamped
  function automatic q16_t scaled_elem(longint term, longint scale);
    longint p;
    p = (term * scale + 64'sd524288) >>> 20;
    if (p > 64'sd2147483647) p = 64'sd2147483647;
    if (p < -64'sd2147483648) p = -64'sd2147483648;
    return q16_t'(p);
  endfunction

  function automatic void push_matrix(in_word_t w);
    longint qx, qy, qz, qw;
    longint s[3];
    longint r[3][3];
    out_word_t col;
    qx = longint'($signed(w.quat_x));
    qy = longint'($signed(w.quat_y));
    qz = longint'($signed(w.quat_z));
    qw = longint'($signed(w.quat_w));
    s[0] = longint'($signed(w.scale_x));
    s[1] = longint'($signed(w.scale_y));
    s[2] = longint'($signed(w.scale_z));
    // r[col][row]
    r[0][0] = (64'sd1 << 28) - 2 * (qy * qy + qz * qz);
    r[0][1] = 2 * (qx * qy + qw * qz);
    r[0][2] = 2 * (qx * qz - qw * qy);
    r[1][0] = 2 * (qx * qy - qw * qz);
    r[1][1] = (64'sd1 << 28) - 2 * (qx * qx + qz * qz);
    r[1][2] = 2 * (qy * qz + qw * qx);
    r[2][0] = 2 * (qx * qz + qw * qy);
    r[2][1] = 2 * (qy * qz - qw * qx);
    r[2][2] = (64'sd1 << 28) - 2 * (qx * qx + qy * qy);
    for (int k = 0; k < 3; k++) begin
      col.column = 2'(k);
      col.elem_row0 = scaled_elem(r[k][0], s[k]);
      col.elem_row1 = scaled_elem(r[k][1], s[k]);
      col.elem_row2 = scaled_elem(r[k][2], s[k]);
      col.elem_row3 = '0;
      col.last = 1'b0;
      column_q.push_back(col);
    end
    col.column = LastCol;
    col.elem_row0 = w.pos_x;
    col.elem_row1 = w.pos_y;
    col.elem_row2 = w.pos_z;
    col.elem_row3 = OneQ16;
    col.last = 1'b1;
    column_q.push_back(col);
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      errors_o++;
    end
  endtask

  always @(posedge clk_i) begin : monitor
    out_word_t exp_col;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) push_matrix(in_word_i);
      if (out_valid_i && out_ready_i) begin
        if (column_q.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual %p", $time, out_word_i);
          errors_o++;
        end else begin
          exp_col = column_q.pop_front();
          check_field("column", 32'(exp_col.column), 32'(out_word_i.column));
          check_field("elem_row0", exp_col.elem_row0, out_word_i.elem_row0);
          check_field("elem_row1", exp_col.elem_row1, out_word_i.elem_row1);
          check_field("elem_row2", exp_col.elem_row2, out_word_i.elem_row2);
          check_field("elem_row3", exp_col.elem_row3, out_word_i.elem_row3);
          check_field("last", 32'(exp_col.last), 32'(out_word_i.last));
        end
      end
      pending_o = column_q.size();
    end
  end

endmodule

// File: tb/trs_matrix_compose_tb.sv
// testbench top for trs_matrix_compose: clock, reset, stimulus, back pressure and verdict
`timescale 1ns / 100ps
module trs_matrix_compose_tb import tmc_pkg::*; ();

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_word;
  int        errors;
  int        pending;
  bit        idle_on;
  bit        hold_req;

  trs_matrix_compose uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_word_o  (out_word)
  );

  trs_matrix_compose_checker checker_i (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_word_i   (in_word),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_word_i  (out_word),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("trs_matrix_compose_tb failed");
    $finish;
  end

  function automatic in_word_t make_word(q16_t px, q16_t py, q16_t pz, q14_t qx, q14_t qy,
                                         q14_t qz, q14_t qw, q8_t sx, q8_t sy, q8_t sz);
    in_word_t w;
    w.pos_x = px;
    w.pos_y = py;
    w.pos_z = pz;
    w.quat_x = qx;
    w.quat_y = qy;
    w.quat_z = qz;
    w.quat_w = qw;
    w.scale_x = sx;
    w.scale_y = sy;
    w.scale_z = sz;
    return w;
  endfunction

  function automatic in_word_t rand_word();
    in_word_t w;
    w.pos_x = $urandom;
    w.pos_y = $urandom;
    w.pos_z = $urandom;
    w.quat_x = q14_t'($urandom_range(0, 65535));
    w.quat_y = q14_t'($urandom_range(0, 65535));
    w.quat_z = q14_t'($urandom_range(0, 65535));
    w.quat_w = q14_t'($urandom_range(0, 65535));
    w.scale_x = q8_t'($urandom_range(0, 65535));
    w.scale_y = q8_t'($urandom_range(0, 65535));
    w.scale_z = q8_t'($urandom_range(0, 65535));
    case ($urandom_range(0, 2))
      0: begin
        // rotation components within +-1.0 with modest scale
        w.quat_x = q14_t'(int'($urandom_range(0, 32768)) - 16384);
        w.quat_y = q14_t'(int'($urandom_range(0, 32768)) - 16384);
        w.quat_z = q14_t'(int'($urandom_range(0, 32768)) - 16384);
        w.quat_w = q14_t'(int'($urandom_range(0, 32768)) - 16384);
        w.scale_x = q8_t'(int'($urandom_range(0, 1024)) - 512);
        w.scale_y = q8_t'(int'($urandom_range(0, 1024)) - 512);
        w.scale_z = q8_t'(int'($urandom_range(0, 1024)) - 512);
      end
      1: begin
        // tiny scale, rounding dominates
        w.scale_x = q8_t'(int'($urandom_range(0, 8)) - 4);
        w.scale_y = q8_t'(int'($urandom_range(0, 8)) - 4);
        w.scale_z = q8_t'(int'($urandom_range(0, 8)) - 4);
      end
      default: ;
    endcase
    return w;
  endfunction

  task automatic send_word(in_word_t w);
    @(negedge clk);
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic pause_input(int n);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic send_random(int n, bit gaps);
    for (int i = 0; i < n; i++) begin
      send_word(rand_word());
      if (gaps && $urandom_range(0, 3) == 0) pause_input($urandom_range(1, 18));
    end
  endtask

  // receiver side back pressure
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (250) @(negedge clk);
        hold_req = 1'b0;
      end else if (!idle_on || $urandom_range(0, 2) != 0) begin
        out_ready <= 1'b1;
        if (idle_on) repeat ($urandom_range(0, 30)) @(negedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat ($urandom_range(0, 17)) @(negedge clk);
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    idle_on = 1'b1;
    hold_req = 1'b0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    send_word(make_word(0, 0, 0, 0, 0, 0, 16384, 256, 256, 256));
    send_word(make_word(SatMax, SatMin, 0, 0, 0, 0, 16384, 256, 256, 256));
    send_word(make_word(-1, 1, 65536, 0, 0, 0, 16384, 256, 256, 256));
    send_word(make_word(SatMin, SatMax, -1, 0, 0, 0, 0, 0, 0, 0));
    send_word(make_word(0, 0, 0, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    send_word(make_word(0, 0, 0, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
    send_word(make_word(0, 0, 0, 32767, 32767, 32767, 32767, -32768, -32768, -32768));
    send_word(make_word(0, 0, 0, 32767, -32768, 32767, -32768, 32767, -32768, 1));
    send_word(make_word(0, 0, 0, -32768, 32767, -32768, 32767, -32768, 32767, -1));
    // exact half-way rounding, both signs
    send_word(make_word(0, 0, 0, 512, 512, 0, 0, 1, 1, 1));
    send_word(make_word(0, 0, 0, 512, 512, 0, 0, -1, -1, -1));
    send_word(make_word(100, -100, 0, 0, 0, 11585, 11585, 256, 512, -256));
    // unnormalized quaternion, shear and stretch
    send_word(make_word(0, 0, 0, 8192, 0, 0, 32767, 256, 256, 256));
    send_word(make_word(1, 2, 3, 16384, 0, 0, 0, 1, -1, 128));
    send_word(make_word(0, 0, 0, 0, 16384, 0, 0, 32767, 0, -32768));

    send_random(150, 1'b1);

    // receiver holds off while words keep coming
    hold_req = 1'b1;
    send_random(40, 1'b0);

    // drain completely before continuing
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (12) @(negedge clk);

    send_random(160, 1'b1);

    idle_on = 1'b0;
    send_random(70, 1'b0);
    @(negedge clk);
    in_valid <= 1'b0;

    wait (pending == 0);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("trs_matrix_compose_tb passed");
    end else begin
      $display("trs_matrix_compose_tb failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/tmc_pkg.sv
sv/tmc_quat_terms.sv
sv/trs_matrix_compose.sv
tb/trs_matrix_compose_checker.sv
tb/trs_matrix_compose_tb.sv
